[design/srcrit_pkg.sv]
// Shared types, codes and widths for the slope refinement criterion block.
package srcrit_pkg;

   // Field value width (signed Q16.16 when 32)
   localparam int VALUE_BITS  = 32;
   localparam int CFG_W       = 32;
   localparam int LEVEL_W     = 6;
   localparam int AXIS_W      = 2;
   localparam int CSR_INDEX_W = 3;

   // Multiplier slicing: 32-bit chunks of |center| times two chunks of t*h
   localparam int CHUNK_W    = 32;
   localparam int C_CHUNKS   = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
   localparam int C_PAD_W    = C_CHUNKS * CHUNK_W;
   localparam int PART_N     = 2 * C_CHUNKS;
   localparam int PART_IDX_W = (PART_N > 1) ? $clog2(PART_N) : 1;
   localparam int TH_W       = 2 * CHUNK_W;
   localparam int ACC_W      = TH_W + C_PAD_W;
   localparam int DIFF_W     = VALUE_BITS + 1;

   // |diff| / (2*h*|c|) > t  <=>  |diff| * 2^39 > t*h*|c| for Q16.16 / Q8.24
   localparam int SLOPE_SHIFT = 39;

   localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(65536);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REFINE_THR  = 3'd0,
      CSR_COARSEN_THR = 3'd1,
      CSR_WIDTH_X     = 3'd2,
      CSR_WIDTH_Y     = 3'd3,
      CSR_WIDTH_Z     = 3'd4,
      CSR_MAX_LEVEL   = 3'd5,
      CSR_BLOCK_LEVEL = 3'd6
   } csr_index_type;

   localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;

   localparam logic [1:0] MARK_UNCHANGED = 2'd0;
   localparam logic [1:0] MARK_ZERO      = 2'd1;
   localparam logic [1:0] MARK_PLUS      = 2'd2;

   localparam logic [1:0] DEC_COARSEN = 2'd0;
   localparam logic [1:0] DEC_SAME    = 2'd1;
   localparam logic [1:0] DEC_REFINE  = 2'd2;

   localparam logic THR_REFINE  = 1'b0;
   localparam logic THR_COARSEN = 1'b1;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] center_value;
      logic signed [VALUE_BITS-1:0] minus_value;
      logic signed [VALUE_BITS-1:0] plus_value;
      logic [AXIS_W-1:0]            axis;
      logic                         last_cell;
   } req_type;

   typedef struct packed {
      logic [1:0] cell_mark;
      logic       decision_valid;
      logic [1:0] decision;
   } rsp_type;

   typedef struct packed {
      logic                  load;
      logic                  mul_th;
      logic                  mul_part;
      logic                  compare;
      logic                  finish;
      logic                  thr_sel;
      logic [PART_IDX_W-1:0] part_idx;
   } cmd_type;

endpackage

[design/srcrit_ctrl.sv]
// Sequencer for the slope test: threshold loop, partial product steps, result handoff.
module srcrit_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output srcrit_pkg::cmd_type cmd
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_TH    = 6'b000010,
      S_PART  = 6'b000100,
      S_DRAIN = 6'b001000,
      S_CMP   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type                         state_ff, state_in;
   logic                              thr_ff, thr_in;
   logic [srcrit_pkg::PART_IDX_W-1:0] part_ff, part_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      thr_in       = thr_ff;
      part_in      = part_ff;
      cmd          = '0;
      cmd.thr_sel  = thr_ff;
      cmd.part_idx = part_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               thr_in   = srcrit_pkg::THR_REFINE;
               state_in = S_TH;
            end
         end
         S_TH: begin
            cmd.mul_th = 1'b1;
            part_in    = '0;
            state_in   = S_PART;
         end
         S_PART: begin
            cmd.mul_part = 1'b1;
            if (part_ff == srcrit_pkg::PART_IDX_W'(srcrit_pkg::PART_N - 1)) begin
               state_in = S_DRAIN;
            end else begin
               part_in = srcrit_pkg::PART_IDX_W'(part_ff + 1'b1);
            end
         end
         S_DRAIN: begin
            // last partial product lands in the accumulator
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            if (thr_ff == srcrit_pkg::THR_REFINE) begin
               thr_in   = srcrit_pkg::THR_COARSEN;
               state_in = S_TH;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= srcrit_pkg::THR_REFINE;
         part_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         part_ff      <= part_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   // an accepted request keeps the input closed until its result is built
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (req_stall && !cmd.finish))
      else $error("input reopened right after accept");

endmodule

[design/srcrit_datapath.sv]
// Datapath: config registers, |diff| and |center|, sliced multiplier, compare, flags, result.
module srcrit_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  srcrit_pkg::cmd_type                 cmd,
   input  srcrit_pkg::req_type                 req_payload,
   input  logic                                csr_valid,
   input  logic [srcrit_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [srcrit_pkg::CFG_W-1:0]        csr_wdata,
   output srcrit_pkg::rsp_type                 rsp_payload
);

   localparam int VB = srcrit_pkg::VALUE_BITS;

   logic [srcrit_pkg::CFG_W-1:0]   refine_thr_ff, coarsen_thr_ff;
   logic [srcrit_pkg::CFG_W-1:0]   width_x_ff, width_y_ff, width_z_ff;
   logic [srcrit_pkg::LEVEL_W-1:0] max_level_ff, block_level_ff;

   logic [srcrit_pkg::DIFF_W-1:0]     d_ff, d_in;
   logic [srcrit_pkg::C_PAD_W-1:0]    c_ff, c_in;
   logic [srcrit_pkg::CFG_W-1:0]      h_ff, h_in;
   logic                              last_ff;
   logic [srcrit_pkg::TH_W-1:0]       th_ff, th_in;
   logic [srcrit_pkg::TH_W-1:0]       prod_ff, prod_in;
   logic [srcrit_pkg::PART_IDX_W-1:0] shift_ff, shift_in;
   logic                              prod_valid_ff;
   logic [srcrit_pkg::ACC_W-1:0]      acc_ff;
   logic                              over_ref_ff, over_coa_ff;
   logic                              refine_seen_ff, coarsen_allowed_ff;
   logic                              refine_seen_in, coarsen_allowed_in;
   srcrit_pkg::rsp_type               out_ff, out_in;

   logic signed [srcrit_pkg::DIFF_W-1:0] diff;
   logic [srcrit_pkg::CFG_W-1:0]         t_sel;
   logic [srcrit_pkg::PART_IDX_W-1:0]    j_idx;
   logic [srcrit_pkg::CHUNK_W-1:0]       a_chunk, c_chunk;
   logic [srcrit_pkg::ACC_W-1:0]         lhs;
   logic                                 over;
   logic                                 rs_next, ca_next;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         refine_thr_ff  <= '0;
         coarsen_thr_ff <= '0;
         width_x_ff     <= srcrit_pkg::WIDTH_RESET;
         width_y_ff     <= srcrit_pkg::WIDTH_RESET;
         width_z_ff     <= srcrit_pkg::WIDTH_RESET;
         max_level_ff   <= '0;
         block_level_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            srcrit_pkg::CSR_REFINE_THR:  refine_thr_ff  <= csr_wdata;
            srcrit_pkg::CSR_COARSEN_THR: coarsen_thr_ff <= csr_wdata;
            srcrit_pkg::CSR_WIDTH_X:     width_x_ff     <= csr_wdata;
            srcrit_pkg::CSR_WIDTH_Y:     width_y_ff     <= csr_wdata;
            srcrit_pkg::CSR_WIDTH_Z:     width_z_ff     <= csr_wdata;
            srcrit_pkg::CSR_MAX_LEVEL:   max_level_ff   <= csr_wdata[srcrit_pkg::LEVEL_W-1:0];
            srcrit_pkg::CSR_BLOCK_LEVEL: block_level_ff <= csr_wdata[srcrit_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // operand capture
   always_comb begin
      diff = {req_payload.plus_value[VB-1], req_payload.plus_value}
           - {req_payload.minus_value[VB-1], req_payload.minus_value};
      d_in = diff[srcrit_pkg::DIFF_W-1] ? srcrit_pkg::DIFF_W'(-diff)
                                        : srcrit_pkg::DIFF_W'(diff);
      c_in = req_payload.center_value[VB-1]
           ? srcrit_pkg::C_PAD_W'(VB'(-req_payload.center_value))
           : srcrit_pkg::C_PAD_W'(VB'(req_payload.center_value));
      if (req_payload.axis == srcrit_pkg::AXIS_X) begin
         h_in = width_x_ff;
      end else if (req_payload.axis == srcrit_pkg::AXIS_Y) begin
         h_in = width_y_ff;
      end else begin
         h_in = width_z_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         d_ff    <= d_in;
         c_ff    <= c_in;
         h_ff    <= h_in;
         last_ff <= req_payload.last_cell;
      end
   end

   // t*h, then (t*h)*|c| one 32x32 partial product per step
   always_comb begin
      t_sel    = (cmd.thr_sel == srcrit_pkg::THR_REFINE) ? refine_thr_ff : coarsen_thr_ff;
      th_in    = srcrit_pkg::TH_W'(t_sel) * srcrit_pkg::TH_W'(h_ff);
      j_idx    = cmd.part_idx >> 1;
      a_chunk  = cmd.part_idx[0] ? th_ff[srcrit_pkg::TH_W-1:srcrit_pkg::CHUNK_W]
                                 : th_ff[srcrit_pkg::CHUNK_W-1:0];
      c_chunk  = srcrit_pkg::CHUNK_W'(c_ff >> {j_idx, 5'b00000});
      prod_in  = srcrit_pkg::TH_W'(a_chunk) * srcrit_pkg::TH_W'(c_chunk);
      shift_in = srcrit_pkg::PART_IDX_W'(j_idx + srcrit_pkg::PART_IDX_W'(cmd.part_idx[0]));
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_th) begin
         th_ff <= th_in;
      end
      if (cmd.mul_part) begin
         prod_ff  <= prod_in;
         shift_ff <= shift_in;
      end
      if (cmd.mul_th) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= srcrit_pkg::ACC_W'(acc_ff
                 + (srcrit_pkg::ACC_W'(prod_ff) << {shift_ff, 5'b00000}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= cmd.mul_part;
      end
   end

   // compare |diff| * 2^39 against t*h*|c|; zero center reduces to diff != 0
   always_comb begin
      lhs  = srcrit_pkg::ACC_W'(d_ff) << srcrit_pkg::SLOPE_SHIFT;
      over = (lhs > acc_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         if (cmd.thr_sel == srcrit_pkg::THR_REFINE) begin
            over_ref_ff <= over;
         end else begin
            over_coa_ff <= over;
         end
      end
   end

   // block flags and result
   always_comb begin
      rs_next            = refine_seen_ff | over_ref_ff;
      ca_next            = coarsen_allowed_ff & ~over_coa_ff;
      refine_seen_in     = refine_seen_ff;
      coarsen_allowed_in = coarsen_allowed_ff;
      out_in             = '0;
      priority if (over_ref_ff) begin
         out_in.cell_mark = srcrit_pkg::MARK_PLUS;
      end else if (over_coa_ff) begin
         out_in.cell_mark = srcrit_pkg::MARK_ZERO;
      end else begin
         out_in.cell_mark = srcrit_pkg::MARK_UNCHANGED;
      end
      if (cmd.finish) begin
         if (last_ff) begin
            out_in.decision_valid = 1'b1;
            priority if (rs_next) begin
               out_in.decision = (block_level_ff >= max_level_ff) ? srcrit_pkg::DEC_SAME
                                                                  : srcrit_pkg::DEC_REFINE;
            end else if (ca_next) begin
               out_in.decision = srcrit_pkg::DEC_COARSEN;
            end else begin
               out_in.decision = srcrit_pkg::DEC_SAME;
            end
            refine_seen_in     = 1'b0;
            coarsen_allowed_in = 1'b1;
         end else begin
            refine_seen_in     = rs_next;
            coarsen_allowed_in = ca_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refine_seen_ff     <= 1'b0;
         coarsen_allowed_ff <= 1'b1;
      end else begin
         refine_seen_ff     <= refine_seen_in;
         coarsen_allowed_ff <= coarsen_allowed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_ff <= out_in;
      end
   end

   assign rsp_payload = out_ff;

   a_decision_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (out_ff.decision_valid || out_ff.decision == srcrit_pkg::DEC_COARSEN))
      else $error("decision set on a non-final result");

   a_level_cap: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (out_ff.decision != srcrit_pkg::DEC_REFINE
                      || $past(block_level_ff < max_level_ff)))
      else $error("refine reported at or above max level");

   a_flags_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && last_ff) |=> (!refine_seen_ff && coarsen_allowed_ff))
      else $error("block flags not cleared after final cell");

endmodule

[design/slope_refinement_criterion_core.sv]
// Top level of the relative slope refinement criterion block.
// Each request carries one cell value with its two neighbors along an axis; the block tests
// |plus - minus| / (2 * h * |center|) against the refine and coarsen thresholds by exact
// cross-multiplication and returns one response per request with the cell mark, and on the
// request marked last_cell also the block decision (refine capped to same at max level),
// after which the block flags clear. Both thresholds go in turn through a 32x32 multiplier
// for t * h and a second one that builds t * h * |center| in 32-bit slices. The next
// request is accepted once the response is registered, even if it is still stalled; until
// then the input is held off. Configuration writes are always ready and must only occur
// while the block is idle.
module slope_refinement_criterion_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  srcrit_pkg::req_type                 req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output srcrit_pkg::rsp_type                 rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [srcrit_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [srcrit_pkg::CFG_W-1:0]        csr_wdata
);

   srcrit_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   srcrit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   srcrit_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_payload (rsp_payload)
   );

endmodule
